// ===== src/kmce_pkg.sv =====
// Shared constants, op codes and types for the k-means clustering engine.
package kmce_pkg;

   localparam int MAX_POINTS_DEF   = 256;
   localparam int MAX_CLUSTERS_DEF = 8;
   localparam int MAX_DIMS_DEF     = 4;
   localparam int COORD_BITS_DEF   = 16;

   localparam logic [2:0] OP_LOAD_POINT    = 3'd0;
   localparam logic [2:0] OP_LOAD_CENTROID = 3'd1;
   localparam logic [2:0] OP_RUN           = 3'd2;
   localparam logic [2:0] OP_READ_ASSIGN   = 3'd3;
   localparam logic [2:0] OP_READ_CENTROID = 3'd4;

   localparam logic [1:0] CSR_CLUSTERS = 2'd0;
   localparam logic [1:0] CSR_DIMS     = 2'd1;
   localparam logic [1:0] CSR_ROUNDS   = 2'd2;

   // Per-lane distance is kept at 64 bits, saturating.
   localparam int DIST_BITS = 64;

   typedef struct packed {
      logic       start;
      logic [3:0] clusters;
      logic [3:0] dims;
   } lane_ctl_type;

endpackage

// ===== src/kmce_dist_lane.sv =====
// One distance lane: sums squared distance to one centroid, one dim per enabled cycle.
module kmce_dist_lane #(
   parameter int COORD_BITS = kmce_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            clear,
   input  logic                            en,
   input  logic signed [COORD_BITS-1:0]    pt,
   input  logic signed [COORD_BITS-1:0]    ctr,
   output logic [kmce_pkg::DIST_BITS-1:0]  sq_sum
);
   localparam int DW = COORD_BITS + 1;
   logic signed [DW-1:0] diff;
   logic [DW-1:0] mag;
   logic [2*DW-1:0] sq;
   logic [kmce_pkg::DIST_BITS:0] sum;
   logic [kmce_pkg::DIST_BITS-1:0] acc_ff, acc_in;

   always_comb begin
      diff = DW'(ctr) - DW'(pt);
      mag  = diff[DW-1] ? DW'(-diff) : diff;
      sq   = (2*DW)'(mag) * (2*DW)'(mag);
      sum  = {1'b0, acc_ff} + (kmce_pkg::DIST_BITS+1)'(sq);
      acc_in = acc_ff;
      if (clear) acc_in = '0;
      else if (en) acc_in = sum[kmce_pkg::DIST_BITS] ? '1 : sum[kmce_pkg::DIST_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign sq_sum = acc_ff;
endmodule

// ===== src/kmce_divider.sv =====
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
module kmce_divider #(
   parameter int NUM_BITS = 32,
   parameter int DEN_BITS = 13,
   parameter int Q_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [NUM_BITS-1:0]  num,
   input  logic [DEN_BITS-1:0]         den,
   output logic                        done,
   output logic [Q_BITS-1:0]           quot
);
   localparam int CW = $clog2(NUM_BITS + 1);
   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [NUM_BITS:0]   r_ff, r_in;
   logic [DEN_BITS-1:0] d_ff, d_in;
   logic                neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [NUM_BITS:0]   trial;
   logic [NUM_BITS-1:0] qres;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      trial = {r_ff[NUM_BITS-1:0], q_ff[NUM_BITS-1]};
      if (start) begin
         neg_in  = num[NUM_BITS-1];
         q_in    = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
         r_in    = '0;
         d_in    = den;
         cnt_in  = CW'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= (NUM_BITS+1)'(d_ff)) begin
            r_in = trial - (NUM_BITS+1)'(d_ff);
            q_in = {q_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign qres = neg_ff ? NUM_BITS'(-q_ff) : q_ff;
   assign quot = qres[Q_BITS-1:0];
   assign done = done_ff;
endmodule

// ===== src/kmeans_clustering_engine_unit.sv =====
// Top level of the k-means clustering engine: stores, lanes, merge and sequencer.
// Usage:
//   req_* carries one command per transfer: load point, load centroid, run,
//   read assignment or read centroid. rsp_* returns one result for run and
//   the reads; loads and unknown ops return nothing.
//   Loads are written when accepted. Reads pass a registered memory read and
//   the response sits in an output register until the receiver takes it;
//   while it waits no new command is accepted.
//   A run works in rounds. Assignment pass: for each point, every lane (one
//   per cluster) accumulates the squared distance one coordinate a cycle,
//   then a merge stage picks the nearest with ties to the lower index; each
//   point takes a fetch state, one state per coordinate (MAX_DIMS of them
//   when dims is 0) and the merge. Accumulation pass: a clear, then a fetch
//   and an accumulate state per point. Update: per non-empty cluster and used
//   coordinate a select state starts the serial divider, else it skips; a
//   closing state ends the round. Run latency is the sum over its rounds;
//   it is set by the single point memory port and the shared divider.
//   After reset the assignment valid bits are cleared at once; configuration
//   registers reset to 5 clusters, 4 dims, 500 rounds. Point and centroid
//   contents are undefined until loaded. On a stall the result holds and
//   req_ready stays low.
module kmeans_clustering_engine_unit #(
   parameter int MAX_POINTS   = kmce_pkg::MAX_POINTS_DEF,
   parameter int MAX_CLUSTERS = kmce_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_DIMS     = kmce_pkg::MAX_DIMS_DEF,
   parameter int COORD_BITS   = kmce_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_op,
   input  logic [7:0]                   req_slot,
   input  logic [8:0]                   req_point_count,
   input  logic signed [COORD_BITS-1:0] req_coord_a,
   input  logic signed [COORD_BITS-1:0] req_coord_b,
   input  logic signed [COORD_BITS-1:0] req_coord_c,
   input  logic signed [COORD_BITS-1:0] req_coord_d,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_cluster_index,
   output logic [15:0]                  rsp_rounds_done,
   output logic                         rsp_converged,
   output logic signed [COORD_BITS-1:0] rsp_mean_a,
   output logic signed [COORD_BITS-1:0] rsp_mean_b,
   output logic signed [COORD_BITS-1:0] rsp_mean_c,
   output logic signed [COORD_BITS-1:0] rsp_mean_d,
   input  logic                         csr_write,
   input  logic [1:0]                   csr_index,
   input  logic [15:0]                  csr_data
);
   localparam int PA = $clog2(MAX_POINTS);
   localparam int KA = $clog2(MAX_CLUSTERS);
   localparam int DA = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CB = $clog2(MAX_POINTS + 1);
   localparam int SB = COORD_BITS + PA + 1;   // signed sum width
   localparam int AW = KA + 1;                // stored assignment: 0 or k+1
   localparam int NIN = (MAX_DIMS < 4) ? MAX_DIMS : 4;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RD    = 4'd1;
   localparam logic [3:0] ST_RSP   = 4'd2;
   localparam logic [3:0] ST_AFET  = 4'd3;
   localparam logic [3:0] ST_ADIM  = 4'd4;
   localparam logic [3:0] ST_AMRG  = 4'd5;
   localparam logic [3:0] ST_CCLR  = 4'd6;
   localparam logic [3:0] ST_CFET  = 4'd7;
   localparam logic [3:0] ST_CACC  = 4'd8;
   localparam logic [3:0] ST_USEL  = 4'd9;
   localparam logic [3:0] ST_UDIV  = 4'd10;
   localparam logic [3:0] ST_RDONE = 4'd11;

   logic [3:0] state_ff, state_in;

   // configuration
   logic [3:0]  clusters_ff;
   logic [2:0]  dims_ff;
   logic [15:0] limit_ff;
   logic [3:0]  kk, dd;

   always_comb begin
      kk = (clusters_ff == 4'd0) ? 4'd1 :
           ({1'b0, clusters_ff} > 5'(MAX_CLUSTERS)) ? 4'(MAX_CLUSTERS) : clusters_ff;
      dd = (4'(dims_ff) > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : 4'(dims_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff <= 4'd5;
         dims_ff     <= 3'd4;
         limit_ff    <= 16'd500;
      end else if (csr_write) begin
         case (csr_index)
            kmce_pkg::CSR_CLUSTERS: clusters_ff <= csr_data[3:0];
            kmce_pkg::CSR_DIMS:     dims_ff     <= csr_data[2:0];
            kmce_pkg::CSR_ROUNDS:   limit_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // stores
   logic [MAX_DIMS*COORD_BITS-1:0] pmem [MAX_POINTS];
   logic [MAX_DIMS*COORD_BITS-1:0] prd_ff;
   logic [AW-1:0]                  amem [MAX_POINTS];
   logic [AW-1:0]                  ard_ff;
   logic [MAX_POINTS-1:0]          aval_ff;
   logic                           aval_rd_ff;
   logic signed [COORD_BITS-1:0]   cent_ff [MAX_CLUSTERS][MAX_DIMS];
   logic signed [SB-1:0]           sums_ff [MAX_CLUSTERS][MAX_DIMS];
   logic [CB-1:0]                  cnt_ff  [MAX_CLUSTERS];

   logic [MAX_DIMS*COORD_BITS-1:0] in_vec;
   always_comb begin
      in_vec = '0;
      in_vec[COORD_BITS-1:0] = req_coord_a;
      if (NIN > 1) in_vec[COORD_BITS*(NIN>1?1:0) +: COORD_BITS] = req_coord_b;
      if (NIN > 2) in_vec[COORD_BITS*(NIN>2?2:0) +: COORD_BITS] = req_coord_c;
      if (NIN > 3) in_vec[COORD_BITS*(NIN>3?3:0) +: COORD_BITS] = req_coord_d;
   end

   logic accept;
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   logic           slot_pt_ok, slot_ct_ok;
   assign slot_pt_ok = (32'(req_slot) < 32'(MAX_POINTS));
   assign slot_ct_ok = (32'(req_slot) < 32'(MAX_CLUSTERS));

   // run bookkeeping
   logic [CB-1:0]  n_ff;
   logic [PA-1:0]  pi_ff, pi_in;
   logic [DA-1:0]  di_ff, di_in;
   logic [15:0]    rounds_ff;
   logic           changed_ff;
   logic [2:0]     rop_ff;
   logic [7:0]     rslot_ff;
   logic           rok_ff;

   // point address mux: command address when idle, held read address while a
   // read is in flight, run index otherwise
   logic [PA-1:0] paddr;
   assign paddr = (state_ff == ST_IDLE) ? PA'(req_slot) :
                  (state_ff == ST_RD || state_ff == ST_RSP) ? PA'(rslot_ff) : pi_ff;

   always_ff @(posedge clock) begin
      if (accept && req_op == kmce_pkg::OP_LOAD_POINT && slot_pt_ok)
         pmem[PA'(req_slot)] <= in_vec;
      prd_ff <= pmem[paddr];
   end

   // lanes
   logic signed [COORD_BITS-1:0] pt_coord;
   logic [kmce_pkg::DIST_BITS-1:0] lane_dist [MAX_CLUSTERS];
   kmce_pkg::lane_ctl_type lctl;
   assign pt_coord = prd_ff[di_ff*COORD_BITS +: COORD_BITS];
   assign lctl.start = (state_ff == ST_AFET);
   assign lctl.clusters = kk;
   assign lctl.dims = dd;

   for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_lane
      kmce_dist_lane #(.COORD_BITS(COORD_BITS)) u_lane (
         .clock (clock),
         .clear (lctl.start),
         .en    ((state_ff == ST_ADIM) && ({1'b0, di_ff} < 4'(lctl.dims))),
         .pt    (pt_coord),
         .ctr   (cent_ff[k][di_ff]),
         .sq_sum(lane_dist[k])
      );
   end

   // merge: nearest lane, ties to the lower index (strict less-than)
   logic [KA-1:0] best;
   logic [kmce_pkg::DIST_BITS-1:0] bestd;
   always_comb begin
      best = '0;
      bestd = lane_dist[0];
      for (int k = 1; k < MAX_CLUSTERS; k++) begin
         if (5'(k) < 5'(lctl.clusters) && lane_dist[k] < bestd) begin
            bestd = lane_dist[k];
            best  = KA'(k);
         end
      end
   end

   // assignment store
   logic          a_we;
   logic [AW-1:0] a_wd;
   logic [AW-1:0] best_code;
   logic [AW-1:0] cur_asg;
   assign best_code = AW'(best) + AW'(1);
   assign cur_asg   = aval_rd_ff ? ard_ff : '0;
   assign a_we = (state_ff == ST_AMRG);
   assign a_wd = best_code;

   always_ff @(posedge clock) begin
      if (a_we) amem[pi_ff] <= a_wd;
      ard_ff     <= amem[paddr];
      aval_rd_ff <= aval_ff[paddr];
   end

   always_ff @(posedge clock) begin
      if (reset) aval_ff <= '0;
      else if (a_we) aval_ff[pi_ff] <= 1'b1;
      else if (accept && req_op == kmce_pkg::OP_LOAD_POINT && slot_pt_ok)
         aval_ff[PA'(req_slot)] <= 1'b0;
   end

   // divider
   logic               dv_start, dv_done;
   logic [COORD_BITS-1:0] dv_q;
   logic [KA-1:0] uk_ff, uk_in;
   logic [DA-1:0] ud_ff, ud_in;
   kmce_divider #(.NUM_BITS(SB), .DEN_BITS(CB), .Q_BITS(COORD_BITS)) u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .num(sums_ff[uk_ff][ud_ff]), .den(cnt_ff[uk_ff]),
      .done(dv_done), .quot(dv_q)
   );

   logic last_pt;
   assign last_pt = ({1'b0, pi_ff} == CB'(n_ff - 1'b1));
   logic [KA-1:0] acc_k;
   assign acc_k = KA'(ard_ff - 1'b1);

   // sequencer
   always_comb begin
      state_in = state_ff;
      pi_in = pi_ff; di_in = di_ff; uk_in = uk_ff; ud_in = ud_ff;
      dv_start = 1'b0;
      case (state_ff)
         ST_IDLE: if (accept) begin
            case (req_op)
               kmce_pkg::OP_RUN: begin
                  pi_in = '0;
                  state_in = ST_AFET;
               end
               kmce_pkg::OP_READ_ASSIGN, kmce_pkg::OP_READ_CENTROID: state_in = ST_RD;
               default: ;
            endcase
         end
         ST_RD:  state_in = ST_RSP;
         ST_RSP: if (rsp_ready) state_in = ST_IDLE;
         ST_AFET: begin
            di_in = '0;
            state_in = (n_ff == '0) ? ST_CCLR : ST_ADIM;
         end
         ST_ADIM: begin
            if ({1'b0, di_ff} >= 4'(dd) - 4'd1 || 4'({1'b0, di_ff}) == 4'(MAX_DIMS-1))
               state_in = ST_AMRG;
            else di_in = di_ff + 1'b1;
         end
         ST_AMRG: begin
            if (last_pt) begin
               pi_in = '0;
               state_in = ST_CCLR;
            end else begin
               pi_in = pi_ff + 1'b1;
               state_in = ST_AFET;
            end
         end
         ST_CCLR: state_in = (n_ff == '0) ? ST_USEL : ST_CFET;
         ST_CFET: state_in = ST_CACC;
         ST_CACC: begin
            if (last_pt) begin
               uk_in = '0; ud_in = '0;
               state_in = ST_USEL;
            end else begin
               pi_in = pi_ff + 1'b1;
               state_in = ST_CFET;
            end
         end
         ST_USEL: begin
            if (5'(uk_ff) >= 5'(kk) || n_ff == '0) state_in = ST_RDONE;
            else if (cnt_ff[uk_ff] == '0 || 4'(ud_ff) >= dd) begin
               ud_in = '0;
               if (5'(uk_ff) == 5'(kk) - 5'd1) state_in = ST_RDONE;
               else uk_in = uk_ff + 1'b1;
            end else begin
               dv_start = 1'b1;
               state_in = ST_UDIV;
            end
         end
         ST_UDIV: if (dv_done) begin
            if ({1'b0, ud_ff} == 4'(MAX_DIMS-1)) begin
               ud_in = '0;
               if (5'(uk_ff) == 5'(kk) - 5'd1) state_in = ST_RDONE;
               else uk_in = uk_ff + 1'b1;
               state_in = (5'(uk_ff) == 5'(kk) - 5'd1) ? ST_RDONE : ST_USEL;
            end else begin
               ud_in = ud_ff + 1'b1;
               state_in = ST_USEL;
            end
         end
         ST_RDONE: begin
            if (!changed_ff || rounds_ff >= limit_ff) state_in = ST_RSP;
            else begin
               pi_in = '0;
               state_in = ST_AFET;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rounds_ff <= '0;
         for (int k = 0; k < MAX_CLUSTERS; k++) cnt_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && accept && req_op == kmce_pkg::OP_RUN)
            rounds_ff <= '0;
         if (state_ff == ST_AFET && pi_ff == '0) rounds_ff <= rounds_ff + 1'b1;
         if (state_ff == ST_CCLR)
            for (int k = 0; k < MAX_CLUSTERS; k++) cnt_ff[k] <= '0;
         if (state_ff == ST_CACC && ard_ff != '0 && aval_rd_ff)
            cnt_ff[acc_k] <= cnt_ff[acc_k] + 1'b1;
      end
      pi_ff <= pi_in; di_ff <= di_in; uk_ff <= uk_in; ud_ff <= ud_in;
      if (accept) begin
         rop_ff   <= req_op;
         rslot_ff <= req_slot;
         rok_ff   <= (req_op == kmce_pkg::OP_READ_ASSIGN) ? slot_pt_ok : slot_ct_ok;
         if (req_op == kmce_pkg::OP_RUN)
            n_ff <= (32'(req_point_count) > 32'(MAX_POINTS)) ? CB'(MAX_POINTS) :
                    CB'(req_point_count);
      end
      if (state_ff == ST_AFET && pi_ff == '0) changed_ff <= 1'b0;
      if (state_ff == ST_AMRG && cur_asg != best_code) changed_ff <= 1'b1;
      if (state_ff == ST_CCLR)
         for (int k = 0; k < MAX_CLUSTERS; k++)
            for (int d = 0; d < MAX_DIMS; d++) sums_ff[k][d] <= '0;
      if (state_ff == ST_CACC && ard_ff != '0 && aval_rd_ff)
         for (int d = 0; d < MAX_DIMS; d++)
            if (4'(d) < dd)
               sums_ff[acc_k][d] <= sums_ff[acc_k][d]
                  + SB'(signed'(prd_ff[d*COORD_BITS +: COORD_BITS]));
      if (accept && req_op == kmce_pkg::OP_LOAD_CENTROID && slot_ct_ok)
         for (int d = 0; d < MAX_DIMS; d++)
            cent_ff[req_slot[KA-1:0]][d] <= in_vec[d*COORD_BITS +: COORD_BITS];
      if (state_ff == ST_UDIV && dv_done) cent_ff[uk_ff][ud_ff] <= dv_q;
   end

   // ST_AMRG reads the stored assignment fetched in ST_AFET/ST_ADIM (same pi)

   // response register
   logic rsp_run;
   assign rsp_run = (rop_ff == kmce_pkg::OP_RUN);
   logic [KA-1:0] rk;
   assign rk = rslot_ff[KA-1:0];
   logic signed [COORD_BITS-1:0] mean [4];
   always_comb begin
      for (int d = 0; d < 4; d++)
         mean[d] = (d < MAX_DIMS && rop_ff == kmce_pkg::OP_READ_CENTROID && rok_ff) ?
                   cent_ff[rk][d < MAX_DIMS ? d : 0] : '0;
   end

   assign rsp_valid         = (state_ff == ST_RSP);
   assign rsp_cluster_index = (rop_ff == kmce_pkg::OP_READ_ASSIGN && rok_ff && aval_rd_ff
                               && ard_ff != '0) ? 3'(ard_ff - 1'b1) : 3'd0;
   assign rsp_rounds_done   = rsp_run ? rounds_ff : 16'd0;
   assign rsp_converged     = rsp_run ? !changed_ff : 1'b0;
   assign rsp_mean_a = mean[0];
   assign rsp_mean_b = mean[1];
   assign rsp_mean_c = mean[2];
   assign rsp_mean_d = mean[3];

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      dv_start |=> state_ff == ST_UDIV) else $error("divider start lost");
endmodule
